FILE: hw/rtl/kpa_pkg.sv
// ----------------------------------------------------------------------------
// kpa_pkg: shared types and constants for the keypad PIN alarm controller
// Word layouts, key codes, configuration indexes and reset values.
// ----------------------------------------------------------------------------
package kpa_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int ENTRY_CNT_W    = 5;
  localparam int PIN_W          = 64;
  localparam int PIN_LEN_W      = 5;
  localparam int ATTEMPT_W      = 4;
  localparam int CFG_IDX_W      = 3;

  // event kinds
  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_REED = 2'd1;
  localparam logic [1:0] OP_PIR  = 2'd2;
  localparam logic [1:0] OP_RFID = 2'd3;

  // decoded key values (digits are 0..9)
  localparam logic [3:0] K_A    = 4'd10;
  localparam logic [3:0] K_B    = 4'd11;
  localparam logic [3:0] K_C    = 4'd12;
  localparam logic [3:0] K_D    = 4'd13;
  localparam logic [3:0] K_STAR = 4'd14;
  localparam logic [3:0] K_HASH = 4'd15;

  // arm modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_SEMI = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USER_PIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_PIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 3'd4;

  localparam logic [PIN_W-1:0]     RST_USER_PIN     = 64'h4321;
  localparam logic [PIN_LEN_W-1:0] RST_USER_LEN     = 5'd4;
  localparam logic [PIN_W-1:0]     RST_MASTER_PIN   = 64'h0;
  localparam logic [PIN_LEN_W-1:0] RST_MASTER_LEN   = 5'd4;
  localparam logic [ATTEMPT_W-1:0] RST_MAX_ATTEMPTS = 4'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic                   lock_open;
    logic                   buzzer_on;
    logic                   alarm_intruder;
    logic                   alarm_attempts;
    logic                   alarm_unauthorized;
    logic [1:0]             armed_mode;
    logic                   blocked;
    logic                   authorized;
    logic                   master_logged_in;
    logic                   master_entry_active;
    logic                   mode_select_active;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic [PIN_W-1:0]     user_pin;
    logic [PIN_LEN_W-1:0] user_len;
    logic [PIN_W-1:0]     master_pin;
    logic [PIN_LEN_W-1:0] master_len;
    logic [ATTEMPT_W-1:0] max_attempts;
  } cfg_t;

  // keypad position (row*4+col) to key value
  function automatic logic [3:0] key_decode(input logic [3:0] pos);
    logic [3:0] k;
    case (pos)
      4'd0:    k = 4'd1;
      4'd1:    k = 4'd2;
      4'd2:    k = 4'd3;
      4'd3:    k = K_A;
      4'd4:    k = 4'd4;
      4'd5:    k = 4'd5;
      4'd6:    k = 4'd6;
      4'd7:    k = K_B;
      4'd8:    k = 4'd7;
      4'd9:    k = 4'd8;
      4'd10:   k = 4'd9;
      4'd11:   k = K_C;
      4'd12:   k = K_STAR;
      4'd13:   k = 4'd0;
      4'd14:   k = K_HASH;
      default: k = K_D;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/kpa_pin_match.sv
// ----------------------------------------------------------------------------
// kpa_pin_match: parallel PIN compare
// Entry matches when its count equals the PIN length and each held digit
// equals the corresponding PIN nibble.
// ----------------------------------------------------------------------------
module kpa_pin_match #(
  parameter int MAX_DIGITS = kpa_pkg::MAX_DIGITS_DEF
) (
  input  logic [MAX_DIGITS-1:0][3:0]            entry,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]       count,
  input  logic [kpa_pkg::PIN_W-1:0]             pin,
  input  logic [kpa_pkg::PIN_LEN_W-1:0]         pin_len,
  output logic                                  match
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [MAX_DIGITS-1:0] dig_ok;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig_ok[i] = (CW'(i) >= count) || (entry[i] == pin[4*i +: 4]);
    end
  end

  assign match = ((kpa_pkg::PIN_LEN_W)'(count) == pin_len) && (&dig_ok);

endmodule

FILE: hw/rtl/kpa_ctrl.sv
// ----------------------------------------------------------------------------
// kpa_ctrl: controller state and per-event update
// Holds entry buffers, fail counters, arm mode, flags and alarms; works out
// the next state for one event and the result word that follows from it.
// ----------------------------------------------------------------------------
module kpa_ctrl #(
  parameter int MAX_DIGITS = kpa_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  kpa_pkg::in_word_t   evt,
  input  kpa_pkg::cfg_t       cfg,
  output kpa_pkg::out_word_t  res
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [MAX_DIGITS-1:0][3:0] user_entry_r, master_entry_r;
  logic [CW-1:0] user_count_r, user_count_nxt, master_count_r, master_count_nxt;
  logic [kpa_pkg::ATTEMPT_W-1:0] ufail_r, ufail_nxt, mfail_r, mfail_nxt;
  logic [kpa_pkg::ATTEMPT_W-1:0] ufail_inc, mfail_inc;
  logic [1:0] mode_r, mode_nxt;
  logic blocked_r, blocked_nxt, auth_r, auth_nxt, lock_r, lock_nxt;
  logic door_r, door_nxt, rfid_ign_r, rfid_ign_nxt;
  logic mentry_r, mentry_nxt, mlogged_r, mlogged_nxt, modesel_r, modesel_nxt;
  logic buzz_r, buzz_nxt, intr_r, intr_nxt, att_r, att_nxt, unauth_r, unauth_nxt;
  logic user_we, master_we;
  logic user_ok, master_ok;
  logic [3:0] key;

  assign key       = kpa_pkg::key_decode(evt.key_code);
  assign ufail_inc = ufail_r + 1'b1;
  assign mfail_inc = mfail_r + 1'b1;

  kpa_pin_match #(.MAX_DIGITS(MAX_DIGITS)) u_user_match (
    .entry   (user_entry_r),
    .count   (user_count_r),
    .pin     (cfg.user_pin),
    .pin_len (cfg.user_len),
    .match   (user_ok)
  );

  kpa_pin_match #(.MAX_DIGITS(MAX_DIGITS)) u_master_match (
    .entry   (master_entry_r),
    .count   (master_count_r),
    .pin     (cfg.master_pin),
    .pin_len (cfg.master_len),
    .match   (master_ok)
  );

  always_comb begin
    user_count_nxt   = user_count_r;
    master_count_nxt = master_count_r;
    ufail_nxt    = ufail_r;
    mfail_nxt    = mfail_r;
    mode_nxt     = mode_r;
    blocked_nxt  = blocked_r;
    auth_nxt     = auth_r;
    lock_nxt     = lock_r;
    door_nxt     = door_r;
    rfid_ign_nxt = rfid_ign_r;
    mentry_nxt   = mentry_r;
    mlogged_nxt  = mlogged_r;
    modesel_nxt  = modesel_r;
    buzz_nxt     = buzz_r;
    intr_nxt     = intr_r;
    att_nxt      = att_r;
    unauth_nxt   = unauth_r;
    user_we      = 1'b0;
    master_we    = 1'b0;

    case (evt.operation)
      kpa_pkg::OP_KEY: begin
        case (key)
          kpa_pkg::K_HASH: begin
            if (mentry_r) begin
              if (master_ok) begin
                mlogged_nxt      = 1'b1;
                mentry_nxt       = 1'b0;
                mfail_nxt        = '0;
                master_count_nxt = '0;
              end else if (mfail_inc >= cfg.max_attempts) begin
                // master lockout: buzzer only, entry kept
                mfail_nxt = '0;
                buzz_nxt  = 1'b1;
              end else begin
                mfail_nxt        = mfail_inc;
                master_count_nxt = '0;
              end
            end else if (mode_r == kpa_pkg::MODE_OFF) begin
              lock_nxt = 1'b1;
            end else if (user_ok) begin
              lock_nxt       = 1'b1;
              auth_nxt       = 1'b1;
              ufail_nxt      = '0;
              user_count_nxt = '0;
            end else if (ufail_inc >= cfg.max_attempts) begin
              att_nxt     = 1'b1;
              buzz_nxt    = 1'b1;
              ufail_nxt   = '0;
              blocked_nxt = 1'b1;
            end else begin
              ufail_nxt      = ufail_inc;
              user_count_nxt = '0;
            end
          end
          kpa_pkg::K_STAR: begin
            if (mentry_r) master_count_nxt = '0;
            else          user_count_nxt   = '0;
          end
          kpa_pkg::K_A: begin
          end
          kpa_pkg::K_B: begin
            if (blocked_r && mlogged_r) begin
              buzz_nxt    = 1'b0;
              intr_nxt    = 1'b0;
              att_nxt     = 1'b0;
              unauth_nxt  = 1'b0;
              blocked_nxt = 1'b0;
            end
          end
          kpa_pkg::K_C: begin
            if (mlogged_r) modesel_nxt = !modesel_r;
          end
          kpa_pkg::K_D: begin
            if (mlogged_r) begin
              mlogged_nxt = 1'b0;
            end else begin
              mentry_nxt       = !mentry_r;
              master_count_nxt = '0;
            end
          end
          default: begin
            // digit; a stale mode select still consumes it
            if (modesel_r) begin
              if (key <= 4'd2) mode_nxt = key[1:0];
              modesel_nxt = 1'b0;
            end
            if (mentry_r) begin
              if (master_count_r < CW'(MAX_DIGITS)) begin
                master_we        = 1'b1;
                master_count_nxt = master_count_r + 1'b1;
              end
            end else if (!blocked_r && !mlogged_r) begin
              if (user_count_r < CW'(MAX_DIGITS)) begin
                user_we        = 1'b1;
                user_count_nxt = user_count_r + 1'b1;
              end
            end
          end
        endcase
      end
      kpa_pkg::OP_REED: begin
        if (lock_r) begin
          if (door_r) begin
            door_nxt     = 1'b0;
            lock_nxt     = 1'b0;
            auth_nxt     = 1'b0;
            rfid_ign_nxt = 1'b1;
          end else begin
            door_nxt = 1'b1;
          end
        end else if (mode_r != kpa_pkg::MODE_OFF && !auth_r) begin
          unauth_nxt  = 1'b1;
          buzz_nxt    = 1'b1;
          blocked_nxt = 1'b1;
        end
      end
      kpa_pkg::OP_PIR: begin
        if (mode_r == kpa_pkg::MODE_FULL && !auth_r) begin
          intr_nxt    = 1'b1;
          buzz_nxt    = 1'b1;
          blocked_nxt = 1'b1;
        end
      end
      default: begin
        if (rfid_ign_r) begin
          rfid_ign_nxt = 1'b0;
        end else if (!auth_r) begin
          lock_nxt = 1'b1;
          auth_nxt = 1'b1;
        end
      end
    endcase
  end

  // entry buffers: no reset, only written slots are ever compared
  always_ff @(posedge clk) begin
    if (step && user_we)   user_entry_r[user_count_r[IW-1:0]]     <= key;
    if (step && master_we) master_entry_r[master_count_r[IW-1:0]] <= key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_count_r   <= '0;
      master_count_r <= '0;
      ufail_r        <= '0;
      mfail_r        <= '0;
      mode_r         <= kpa_pkg::MODE_OFF;
      blocked_r      <= 1'b0;
      auth_r         <= 1'b0;
      lock_r         <= 1'b0;
      door_r         <= 1'b0;
      rfid_ign_r     <= 1'b0;
      mentry_r       <= 1'b0;
      mlogged_r      <= 1'b0;
      modesel_r      <= 1'b0;
      buzz_r         <= 1'b0;
      intr_r         <= 1'b0;
      att_r          <= 1'b0;
      unauth_r       <= 1'b0;
    end else if (step) begin
      user_count_r   <= user_count_nxt;
      master_count_r <= master_count_nxt;
      ufail_r        <= ufail_nxt;
      mfail_r        <= mfail_nxt;
      mode_r         <= mode_nxt;
      blocked_r      <= blocked_nxt;
      auth_r         <= auth_nxt;
      lock_r         <= lock_nxt;
      door_r         <= door_nxt;
      rfid_ign_r     <= rfid_ign_nxt;
      mentry_r       <= mentry_nxt;
      mlogged_r      <= mlogged_nxt;
      modesel_r      <= modesel_nxt;
      buzz_r         <= buzz_nxt;
      intr_r         <= intr_nxt;
      att_r          <= att_nxt;
      unauth_r       <= unauth_nxt;
    end
  end

  always_comb begin
    res.lock_open           = lock_nxt;
    res.buzzer_on           = buzz_nxt;
    res.alarm_intruder      = intr_nxt;
    res.alarm_attempts      = att_nxt;
    res.alarm_unauthorized  = unauth_nxt;
    res.armed_mode          = mode_nxt;
    res.blocked             = blocked_nxt;
    res.authorized          = auth_nxt;
    res.master_logged_in    = mlogged_nxt;
    res.master_entry_active = mentry_nxt;
    res.mode_select_active  = modesel_nxt;
    res.entry_count         = mentry_nxt ? (kpa_pkg::ENTRY_CNT_W)'(master_count_nxt)
                                         : (kpa_pkg::ENTRY_CNT_W)'(user_count_nxt);
  end

endmodule

FILE: hw/rtl/keypad_pin_alarm_controller.sv
// ----------------------------------------------------------------------------
// keypad_pin_alarm_controller: keypad PIN security lock with alarm lines
// Path: an accepted word goes into the input register, then the state update
// lands in the result register; a stalled result slot holds it in between.
// Throughput: one word per cycle while out_ready holds; single-pass update.
// Reset (rst_n, synchronous): flags, counters, mode and alarms cleared,
// configuration back to defaults; entry buffers are not cleared.
// ----------------------------------------------------------------------------
module keypad_pin_alarm_controller #(
  parameter int MAX_DIGITS = kpa_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // event input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  kpa_pkg::in_word_t                 in_data,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output kpa_pkg::out_word_t                out_data,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [kpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kpa_pkg::PIN_W-1:0]         cfg_wdata
);

  // input register
  logic               in_vld_r;
  kpa_pkg::in_word_t  in_word_r;
  // result register
  logic               out_vld_r;
  kpa_pkg::out_word_t out_word_r;
  kpa_pkg::out_word_t res;
  kpa_pkg::cfg_t      cfg_r;
  logic               advance;

  // An event moves from the input register into the state and result
  // register whenever the result slot is empty or being drained.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_word_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_word_r <= res;
  end

  // configuration registers; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.user_pin     <= kpa_pkg::RST_USER_PIN;
      cfg_r.user_len     <= kpa_pkg::RST_USER_LEN;
      cfg_r.master_pin   <= kpa_pkg::RST_MASTER_PIN;
      cfg_r.master_len   <= kpa_pkg::RST_MASTER_LEN;
      cfg_r.max_attempts <= kpa_pkg::RST_MAX_ATTEMPTS;
    end else if (cfg_we) begin
      case (cfg_index)
        kpa_pkg::CFG_USER_PIN:     cfg_r.user_pin     <= cfg_wdata;
        kpa_pkg::CFG_USER_LEN:     cfg_r.user_len     <= cfg_wdata[kpa_pkg::PIN_LEN_W-1:0];
        kpa_pkg::CFG_MASTER_PIN:   cfg_r.master_pin   <= cfg_wdata;
        kpa_pkg::CFG_MASTER_LEN:   cfg_r.master_len   <= cfg_wdata[kpa_pkg::PIN_LEN_W-1:0];
        kpa_pkg::CFG_MAX_ATTEMPTS: cfg_r.max_attempts <= cfg_wdata[kpa_pkg::ATTEMPT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kpa_ctrl #(.MAX_DIGITS(MAX_DIGITS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .evt   (in_word_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

endmodule
